// ===== design/mpoc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpoc_pkg
// Shared widths, command codes and status codes of the multi-pattern counter.
// ----------------------------------------------------------------------------
package mpoc_pkg;

    localparam int SYM_W  = 7;
    localparam int ID_W   = 11;
    localparam int CNT_W  = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 40;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam cmd_t CMD_CLEAR_ALL = 3'd0;
    localparam cmd_t CMD_PAT_SYM   = 3'd1;
    localparam cmd_t CMD_PAT_END   = 3'd2;
    localparam cmd_t CMD_BUILD     = 3'd3;
    localparam cmd_t CMD_SCAN      = 3'd4;
    localparam cmd_t CMD_READ      = 3'd5;
    localparam cmd_t CMD_CLEAR_CNT = 3'd6;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_PHASE = 2'd2;
    localparam status_t STAT_RANGE = 2'd3;

endpackage

// ===== design/mpoc_goto_mem.sv =====
// ----------------------------------------------------------------------------
// mpoc_goto_mem
// Goto targets (two read ports, one write port) and per-row edge valid bits.
// ----------------------------------------------------------------------------
module mpoc_goto_mem #(
    parameter int NODES    = 4096,
    parameter int ALPHABET = 128
) (
    input  logic                                              clk,
    input  logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]        ra_addr,
    input  logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]        rb_addr,
    output logic [$clog2(NODES)-1:0]                          ra_data,
    output logic [$clog2(NODES)-1:0]                          rb_data,
    input  logic                                              t_we,
    input  logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]        t_waddr,
    input  logic [$clog2(NODES)-1:0]                          t_wdata,
    input  logic [$clog2(NODES)-1:0]                          v_raddr,
    output logic [ALPHABET-1:0]                               v_rdata,
    input  logic                                              v_we,
    input  logic [$clog2(NODES)-1:0]                          v_waddr,
    input  logic [ALPHABET-1:0]                               v_wdata
);
    localparam int NW = $clog2(NODES);
    localparam int GW = $clog2(NODES) + $clog2(ALPHABET);

    logic [NW-1:0]       tgt_mem [(2**GW)];
    logic [ALPHABET-1:0] vld_mem [NODES];

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tgt_mem[t_waddr] <= t_wdata;
        end
        ra_data <= tgt_mem[ra_addr];
        rb_data <= tgt_mem[rb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vld_mem[v_waddr] <= v_wdata;
        end
        v_rdata <= vld_mem[v_raddr];
    end

endmodule

// ===== design/mpoc_node_mem.sv =====
// ----------------------------------------------------------------------------
// mpoc_node_mem
// Per-node failure links and end tags, plus the breadth-first walk queue.
// ----------------------------------------------------------------------------
module mpoc_node_mem #(
    parameter int NODES = 4096
) (
    input  logic                           clk,
    input  logic [$clog2(NODES)-1:0]       r_addr,
    output logic [$clog2(NODES)-1:0]       fail_rdata,
    output logic [mpoc_pkg::ID_W-1:0]      tag_rdata,
    input  logic                           fail_we,
    input  logic [$clog2(NODES)-1:0]       fail_waddr,
    input  logic [$clog2(NODES)-1:0]       fail_wdata,
    input  logic                           tag_we,
    input  logic [$clog2(NODES)-1:0]       tag_waddr,
    input  logic [mpoc_pkg::ID_W-1:0]      tag_wdata,
    input  logic [$clog2(NODES)-1:0]       q_raddr,
    output logic [$clog2(NODES)-1:0]       q_rdata,
    input  logic                           q_we,
    input  logic [$clog2(NODES)-1:0]       q_waddr,
    input  logic [$clog2(NODES)-1:0]       q_wdata
);
    import mpoc_pkg::*;

    localparam int NW = $clog2(NODES);

    logic [NW-1:0]   fail_mem [NODES];
    logic [ID_W-1:0] tag_mem  [NODES];
    logic [NW-1:0]   q_mem    [NODES];

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fail_rdata <= fail_mem[r_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rdata <= tag_mem[r_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata <= q_mem[q_raddr];
    end

endmodule

// ===== design/mpoc_cnt_mem.sv =====
// ----------------------------------------------------------------------------
// mpoc_cnt_mem
// Occurrence counts with a saturating increment, or a clear, on write-back.
// ----------------------------------------------------------------------------
module mpoc_cnt_mem #(
    parameter int PATTERNS = 1024
) (
    input  logic                                          clk,
    input  logic [((PATTERNS > 1) ? $clog2(PATTERNS) : 1)-1:0] raddr,
    output logic [mpoc_pkg::CNT_W-1:0]                    rdata,
    input  logic                                          we,
    input  logic                                          inc,
    input  logic [((PATTERNS > 1) ? $clog2(PATTERNS) : 1)-1:0] waddr
);
    import mpoc_pkg::*;

    logic [CNT_W-1:0] cnt_mem [PATTERNS];
    logic [CNT_W-1:0] wdata;

    // increment the value just read, hold at the top; otherwise clear
    always_comb
    begin
        if (!inc)
        begin
            wdata = '0;
        end
        else if (rdata == '1)
        begin
            wdata = rdata;
        end
        else
        begin
            wdata = rdata + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cnt_mem[waddr] <= wdata;
        end
        rdata <= cnt_mem[raddr];
    end

endmodule

// ===== design/multi_pattern_occurrence_counter_top.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_occurrence_counter_top
// Aho-Corasick engine: trie load, failure-link build, scan and count readback.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)                          width
//  s_axis    in   command[2:0] symbol[9:3] pattern_id[20:10]   24
//  m_axis    out  status[1:0] count[33:2]                      40
//
//  One command is worked at a time; each gives exactly one result transfer.
//  Clear counts / clear all zero one count entry a cycle; scan walks the
//  failure chain node by node; build makes two goto reads a symbol through
//  the dual-read goto store.
//  After reset the same count clearing pass runs before s_tready rises.
//  A new command is taken while the previous result still waits on m_axis.
// ----------------------------------------------------------------------------
module multi_pattern_occurrence_counter_top #(
    parameter int NODES    = 4096,
    parameter int ALPHABET = 128,
    parameter int PATTERNS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mpoc_pkg::IN_W-1:0]     s_tdata,   // command, symbol, pattern_id
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mpoc_pkg::OUT_W-1:0]    m_tdata    // status, count
);
    import mpoc_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int AW = $clog2(ALPHABET);
    localparam int GW = NW + AW;
    localparam int PW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;

    // controller states
    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_NEW  = 4'd3;
    localparam logic [3:0] S_RD_CNT   = 4'd4;
    localparam logic [3:0] S_BLD_Q    = 4'd5;
    localparam logic [3:0] S_BLD_NODE = 4'd6;
    localparam logic [3:0] S_BLD_RD   = 4'd7;
    localparam logic [3:0] S_BLD_WR   = 4'd8;
    localparam logic [3:0] S_SCAN_GO  = 4'd9;
    localparam logic [3:0] S_SCAN_T   = 4'd10;
    localparam logic [3:0] S_SCAN_C   = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic [NW-1:0]       ins_reg, ins_next;
    logic [NW-1:0]       scan_reg, scan_next;
    logic [NW:0]         used_reg, used_next;
    logic                built_reg, built_next;
    logic [NW-1:0]       head_reg, head_next;
    logic [NW-1:0]       tail_reg, tail_next;
    logic [NW-1:0]       node_reg, node_next;
    logic [NW-1:0]       fail_reg, fail_next;
    logic [ALPHABET-1:0] row_reg, row_next;
    logic [AW-1:0]       s_reg, s_next;
    logic [NW-1:0]       t_reg, t_next;
    logic [PW-1:0]       cidx_reg, cidx_next;
    logic [PW-1:0]       clr_reg, clr_next;
    logic                clr_root_reg, clr_root_next;
    logic                boot_reg, boot_next;
    logic                byp_reg, byp_next;
    logic [NW-1:0]       byp_node_reg, byp_node_next;
    status_t             res_st_reg, res_st_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic                ovalid_reg, ovalid_next;
    status_t             ost_reg, ost_next;
    logic [CNT_W-1:0]    ocnt_reg, ocnt_next;

    // memory ports
    logic [GW-1:0]       ga_addr, gb_addr, gw_addr;
    logic [NW-1:0]       ga_data, gb_data, gw_data;
    logic                gw_en;
    logic [NW-1:0]       v_raddr, v_waddr;
    logic [ALPHABET-1:0] v_rdata, v_wdata;
    logic                v_we;
    logic [NW-1:0]       n_raddr, f_rdata, f_waddr, f_wdata;
    logic [ID_W-1:0]     tg_rdata, tg_wdata;
    logic [NW-1:0]       tg_waddr;
    logic                f_we, tg_we;
    logic [NW-1:0]       q_raddr, q_rdata, q_waddr, q_wdata;
    logic                q_we;
    logic [PW-1:0]       c_raddr, c_waddr;
    logic [CNT_W-1:0]    c_rdata;
    logic                c_we, c_inc;

    cmd_t                in_cmd;
    logic [SYM_W-1:0]    in_sym;
    logic [ID_W-1:0]     in_id;
    logic                in_take, out_free, sym_ok, id_ok, tag_ok;
    logic [AW-1:0]       sym_i;
    logic [NW-1:0]       via;
    logic [NW-1:0]       q_head;

    assign in_cmd   = s_tdata[2:0];
    assign in_sym   = s_tdata[9:3];
    assign in_id    = s_tdata[20:10];
    assign s_tready = (state_reg == S_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign sym_ok   = (32'(in_sym) < ALPHABET);
    assign id_ok    = (in_id != '0) && (32'(in_id) <= PATTERNS);
    assign tag_ok   = (tg_rdata != '0) && (32'(tg_rdata) <= PATTERNS);
    assign sym_i    = AW'(sym_reg);
    // the root sends every missing edge, and each child's failure, to itself
    assign via      = (node_reg == '0) ? '0 : gb_data;
    // a queue entry written in the same cycle as its read comes from the bypass
    assign q_head   = byp_reg ? byp_node_reg : q_rdata;

    assign m_tvalid       = ovalid_reg;
    assign m_tdata[1:0]   = ost_reg;
    assign m_tdata[33:2]  = ocnt_reg;
    assign m_tdata[39:34] = '0;

    mpoc_goto_mem #(.NODES(NODES), .ALPHABET(ALPHABET)) u_goto (
        .clk     (clk),
        .ra_addr (ga_addr),
        .rb_addr (gb_addr),
        .ra_data (ga_data),
        .rb_data (gb_data),
        .t_we    (gw_en),
        .t_waddr (gw_addr),
        .t_wdata (gw_data),
        .v_raddr (v_raddr),
        .v_rdata (v_rdata),
        .v_we    (v_we),
        .v_waddr (v_waddr),
        .v_wdata (v_wdata)
    );

    mpoc_node_mem #(.NODES(NODES)) u_node (
        .clk        (clk),
        .r_addr     (n_raddr),
        .fail_rdata (f_rdata),
        .tag_rdata  (tg_rdata),
        .fail_we    (f_we),
        .fail_waddr (f_waddr),
        .fail_wdata (f_wdata),
        .tag_we     (tg_we),
        .tag_waddr  (tg_waddr),
        .tag_wdata  (tg_wdata),
        .q_raddr    (q_raddr),
        .q_rdata    (q_rdata),
        .q_we       (q_we),
        .q_waddr    (q_waddr),
        .q_wdata    (q_wdata)
    );

    mpoc_cnt_mem #(.PATTERNS(PATTERNS)) u_cnt (
        .clk   (clk),
        .raddr (c_raddr),
        .rdata (c_rdata),
        .we    (c_we),
        .inc   (c_inc),
        .waddr (c_waddr)
    );

    always_comb
    begin
        state_next    = state_reg;
        sym_next      = sym_reg;
        ins_next      = ins_reg;
        scan_next     = scan_reg;
        used_next     = used_reg;
        built_next    = built_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        node_next     = node_reg;
        fail_next     = fail_reg;
        row_next      = row_reg;
        s_next        = s_reg;
        t_next        = t_reg;
        cidx_next     = cidx_reg;
        clr_next      = clr_reg;
        clr_root_next = clr_root_reg;
        boot_next     = boot_reg;
        byp_next      = byp_reg;
        byp_node_next = byp_node_reg;
        res_st_next   = res_st_reg;
        res_cnt_next  = res_cnt_reg;
        ovalid_next   = ovalid_reg && !m_tready;
        ost_next      = ost_reg;
        ocnt_next     = ocnt_reg;

        ga_addr  = '0;
        gb_addr  = '0;
        gw_en    = 1'b0;
        gw_addr  = '0;
        gw_data  = '0;
        v_raddr  = '0;
        v_we     = 1'b0;
        v_waddr  = '0;
        v_wdata  = '0;
        n_raddr  = '0;
        f_we     = 1'b0;
        f_waddr  = '0;
        f_wdata  = '0;
        tg_we    = 1'b0;
        tg_waddr = '0;
        tg_wdata = '0;
        q_raddr  = '0;
        q_we     = 1'b0;
        q_waddr  = '0;
        q_wdata  = '0;
        c_raddr  = '0;
        c_we     = 1'b0;
        c_inc    = 1'b0;
        c_waddr  = '0;

        unique case (state_reg)
            S_CLR:
            begin
                // zero one count a cycle; on a full clear also empty the root
                c_we    = 1'b1;
                c_waddr = clr_reg;
                if (clr_root_reg)
                begin
                    v_we  = 1'b1;
                    tg_we = 1'b1;
                end
                clr_next = clr_reg + PW'(1);
                if (clr_reg == PW'(PATTERNS - 1))
                begin
                    // the pass after reset answers nothing
                    boot_next = 1'b0;
                    if (boot_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    sym_next     = in_sym;
                    res_st_next  = STAT_OK;
                    res_cnt_next = '0;
                    state_next   = S_FIN;
                    unique case (in_cmd)
                        CMD_CLEAR_ALL:
                        begin
                            clr_root_next = 1'b1;
                            clr_next      = '0;
                            used_next     = (NW+1)'(1);
                            ins_next      = '0;
                            scan_next     = '0;
                            built_next    = 1'b0;
                            state_next    = S_CLR;
                        end
                        CMD_PAT_SYM:
                        begin
                            if (built_reg)
                            begin
                                res_st_next = STAT_PHASE;
                            end
                            else if (!sym_ok)
                            begin
                                res_st_next = STAT_RANGE;
                            end
                            else
                            begin
                                ga_addr    = {ins_reg, AW'(in_sym)};
                                v_raddr    = ins_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_PAT_END:
                        begin
                            if (built_reg)
                            begin
                                res_st_next = STAT_PHASE;
                            end
                            else
                            begin
                                if (!id_ok)
                                begin
                                    res_st_next = STAT_RANGE;
                                end
                                else
                                begin
                                    tg_we    = 1'b1;
                                    tg_waddr = ins_reg;
                                    tg_wdata = in_id;
                                end
                                ins_next = '0;
                            end
                        end
                        CMD_BUILD:
                        begin
                            if (built_reg)
                            begin
                                res_st_next = STAT_PHASE;
                            end
                            else
                            begin
                                node_next  = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                v_raddr    = '0;
                                state_next = S_BLD_NODE;
                            end
                        end
                        CMD_SCAN:
                        begin
                            if (!built_reg)
                            begin
                                res_st_next = STAT_PHASE;
                            end
                            else if (!sym_ok)
                            begin
                                res_st_next = STAT_RANGE;
                            end
                            else
                            begin
                                ga_addr    = {scan_reg, AW'(in_sym)};
                                state_next = S_SCAN_GO;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!id_ok)
                            begin
                                res_st_next = STAT_RANGE;
                            end
                            else
                            begin
                                c_raddr    = PW'(in_id - ID_W'(1));
                                state_next = S_RD_CNT;
                            end
                        end
                        CMD_CLEAR_CNT:
                        begin
                            clr_root_next = 1'b0;
                            clr_next      = '0;
                            scan_next     = '0;
                            state_next    = S_CLR;
                        end
                        default:
                        begin
                            res_st_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                state_next = S_FIN;
                if (v_rdata[sym_i])
                begin
                    ins_next = ga_data;
                end
                else if (used_reg == (NW+1)'(NODES))
                begin
                    res_st_next = STAT_FULL;
                end
                else
                begin
                    gw_en      = 1'b1;
                    gw_addr    = {ins_reg, sym_i};
                    gw_data    = used_reg[NW-1:0];
                    v_we       = 1'b1;
                    v_waddr    = ins_reg;
                    v_wdata    = v_rdata | (ALPHABET'(1) << sym_i);
                    tg_we      = 1'b1;
                    tg_waddr   = used_reg[NW-1:0];
                    ins_next   = used_reg[NW-1:0];
                    used_next  = used_reg + (NW+1)'(1);
                    state_next = S_INS_NEW;
                end
            end
            S_INS_NEW:
            begin
                // empty the new node's edge row
                v_we       = 1'b1;
                v_waddr    = ins_reg;
                state_next = S_FIN;
            end
            S_RD_CNT:
            begin
                res_cnt_next = c_rdata;
                state_next   = S_FIN;
            end
            S_BLD_Q:
            begin
                node_next  = q_head;
                n_raddr    = q_head;
                v_raddr    = q_head;
                head_next  = head_reg + NW'(1);
                state_next = S_BLD_NODE;
            end
            S_BLD_NODE:
            begin
                row_next   = v_rdata;
                fail_next  = f_rdata;
                s_next     = '0;
                state_next = S_BLD_RD;
            end
            S_BLD_RD:
            begin
                ga_addr    = {node_reg, s_reg};
                gb_addr    = {fail_reg, s_reg};
                state_next = S_BLD_WR;
            end
            S_BLD_WR:
            begin
                if (!row_reg[s_reg])
                begin
                    gw_en   = 1'b1;
                    gw_addr = {node_reg, s_reg};
                    gw_data = via;
                end
                else
                begin
                    f_we      = 1'b1;
                    f_waddr   = ga_data;
                    f_wdata   = via;
                    q_we      = 1'b1;
                    q_waddr   = tail_reg;
                    q_wdata   = ga_data;
                    tail_next = tail_reg + NW'(1);
                end
                s_next     = s_reg + AW'(1);
                state_next = S_BLD_RD;
                if (s_reg == AW'(ALPHABET - 1))
                begin
                    v_we    = 1'b1;
                    v_waddr = node_reg;
                    v_wdata = '1;
                    if (head_reg != tail_next)
                    begin
                        q_raddr       = head_reg;
                        byp_next      = row_reg[s_reg] && (tail_reg == head_reg);
                        byp_node_next = ga_data;
                        state_next    = S_BLD_Q;
                    end
                    else
                    begin
                        built_next = 1'b1;
                        ins_next   = '0;
                        scan_next  = '0;
                        state_next = S_FIN;
                    end
                end
            end
            S_SCAN_GO:
            begin
                scan_next = ga_data;
                t_next    = ga_data;
                n_raddr   = ga_data;
                if (ga_data == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN_T;
                end
            end
            S_SCAN_T:
            begin
                t_next = f_rdata;
                if (tag_ok)
                begin
                    cidx_next  = PW'(tg_rdata - ID_W'(1));
                    c_raddr    = PW'(tg_rdata - ID_W'(1));
                    state_next = S_SCAN_C;
                end
                else if (f_rdata == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    n_raddr = f_rdata;
                end
            end
            S_SCAN_C:
            begin
                c_we    = 1'b1;
                c_inc   = 1'b1;
                c_waddr = cidx_reg;
                n_raddr = t_reg;
                if (t_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN_T;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ost_next    = res_st_reg;
                    ocnt_next   = res_cnt_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            sym_reg      <= '0;
            ins_reg      <= '0;
            scan_reg     <= '0;
            used_reg     <= (NW+1)'(1);
            built_reg    <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            node_reg     <= '0;
            fail_reg     <= '0;
            row_reg      <= '0;
            s_reg        <= '0;
            t_reg        <= '0;
            cidx_reg     <= '0;
            clr_reg      <= '0;
            clr_root_reg <= 1'b1;
            boot_reg     <= 1'b1;
            byp_reg      <= 1'b0;
            byp_node_reg <= '0;
            res_st_reg   <= STAT_OK;
            res_cnt_reg  <= '0;
            ovalid_reg   <= 1'b0;
            ost_reg      <= STAT_OK;
            ocnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sym_reg      <= sym_next;
            ins_reg      <= ins_next;
            scan_reg     <= scan_next;
            used_reg     <= used_next;
            built_reg    <= built_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            node_reg     <= node_next;
            fail_reg     <= fail_next;
            row_reg      <= row_next;
            s_reg        <= s_next;
            t_reg        <= t_next;
            cidx_reg     <= cidx_next;
            clr_reg      <= clr_next;
            clr_root_reg <= clr_root_next;
            boot_reg     <= boot_next;
            byp_reg      <= byp_next;
            byp_node_reg <= byp_node_next;
            res_st_reg   <= res_st_next;
            res_cnt_reg  <= res_cnt_next;
            ovalid_reg   <= ovalid_next;
            ost_reg      <= ost_next;
            ocnt_reg     <= ocnt_next;
        end
    end

endmodule

// ===== design/mpoc_checker.sv =====
// ----------------------------------------------------------------------------
// mpoc_checker
// Port-level checks on the counter's command and result streams.
// ----------------------------------------------------------------------------
module mpoc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [mpoc_pkg::IN_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [mpoc_pkg::OUT_W-1:0] m_tdata
);
    import mpoc_pkg::*;

    logic [1:0] pend_reg;
    cmd_t       last_cmd_reg;
    logic       s_xfer, m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            last_cmd_reg <= CMD_CLEAR_ALL;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(s_xfer) - 2'(m_xfer);
            if (s_xfer)
            begin
                last_cmd_reg <= s_tdata[2:0];
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != STAT_OK |-> m_tdata[33:2] == '0)
        else $error("nonzero count with error status");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != '0)
        else $error("result without an outstanding command");

    a_full_src: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && pend_reg == 2'd1 && m_tdata[1:0] == STAT_FULL
        |-> last_cmd_reg == CMD_PAT_SYM)
        else $error("store-full status for a command other than pattern symbol");

endmodule

bind multi_pattern_occurrence_counter_top mpoc_checker u_mpoc_checker (.*);
